/* hw/rtl/shdb_pkg.sv */
// ----------------------------------------------------------------------------
// shdb_pkg
// shared types, register indexes and the sine table generator for the
// smoothed heaviside density blend
// ----------------------------------------------------------------------------
package shdb_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_HALF_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RHO_HEAVY      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RHO_LIGHT      = 2'd3;

  // register reset values
  localparam logic [30:0] HALF_WIDTH_RST     = 31'd65536;
  localparam logic [30:0] INV_HALF_WIDTH_RST = 31'd65536;
  localparam logic [31:0] RHO_HEAVY_RST      = 32'd65536000;
  localparam logic [31:0] RHO_LIGHT_RST      = 32'd80282;

  // weight of one in q1.16
  localparam logic [16:0] H_ONE = 17'd65536;

  // pi squared in q.30 and the taylor series divisors (2n)(2n+1)
  localparam logic [63:0] PI_SQ_Q30    = 64'd10597407032;
  localparam int unsigned SERIES_TERMS = 12;
  localparam logic [63:0] SERIES_DIV [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // control bits that travel with each word down the pipeline
  typedef struct packed {
    logic valid;
    logic above;   // phi beyond +eps
    logic below;   // phi beyond -eps
    logic neg;     // phi negative
  } shdb_ctl_t;

  // one table entry sin(pi*u)/pi in q.16, u = k / 2^addr_bits,
  // folded about one half and summed as a truncated series in q.30
  function automatic logic [15:0] sine_entry(input int unsigned k,
                                             input int unsigned addr_bits);
    logic [63:0]        n_tab;
    logic [63:0]        m;
    logic [63:0]        v;
    logic [63:0]        v2;
    logic [63:0]        w;
    logic [63:0]        term;
    logic signed [63:0] sum;
    n_tab = 64'd1 << addr_bits;
    m     = (64'(k) <= (n_tab >> 1)) ? 64'(k) : n_tab - 64'(k);
    v     = m << (30 - addr_bits);
    v2    = (v * v) >> 30;
    w     = (PI_SQ_Q30 * v2) >> 30;
    term  = v;
    sum   = $signed(v);
    for (int unsigned n = 1; n <= SERIES_TERMS; n++) begin
      term = ((term * w) >> 30) / SERIES_DIV[n];
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    return 16'(($unsigned(sum) + 64'd8192) >> 14);
  endfunction

endpackage

/* hw/rtl/shdb_scale.sv */
// ----------------------------------------------------------------------------
// shdb_scale
// band test, magnitude of phi and scaling by the reciprocal half width
// ----------------------------------------------------------------------------
module shdb_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  logic signed [31:0]  phi_i,
  input  logic [30:0]         half_width_i,
  input  logic [30:0]         inv_half_width_i,
  output shdb_pkg::shdb_ctl_t ctl_o,
  output logic [62:0]         prod_o
);
  import shdb_pkg::*;

  shdb_ctl_t          s1_ctl_d, s1_ctl_q;
  shdb_ctl_t          s2_ctl_q;
  logic [31:0]        s1_mag_d, s1_mag_q;
  logic [62:0]        s2_prod_d, s2_prod_q;
  logic signed [32:0] phi_ext;
  logic signed [32:0] eps_pos;
  logic signed [32:0] eps_neg;

  // band compare against +eps and -eps, magnitude of phi
  always_comb begin
    phi_ext        = {phi_i[31], phi_i};
    eps_pos        = $signed({2'b00, half_width_i});
    eps_neg        = 33'sd0 - eps_pos;
    s1_ctl_d.valid = valid_i;
    s1_ctl_d.above = phi_ext > eps_pos;
    s1_ctl_d.below = phi_ext < eps_neg;
    s1_ctl_d.neg   = phi_i[31];
    s1_mag_d       = phi_i[31] ? 32'(32'd0 - $unsigned(phi_i)) : $unsigned(phi_i);
  end

  // magnitude times reciprocal half width
  assign s2_prod_d = 63'(s1_mag_q) * 63'(inv_half_width_i);

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
    end else if (adv_i) begin
      s1_ctl_q <= s1_ctl_d;
      s2_ctl_q <= s1_ctl_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_mag_q  <= s1_mag_d;
      s2_prod_q <= s2_prod_d;
    end
  end

  assign ctl_o  = s2_ctl_q;
  assign prod_o = s2_prod_q;

endmodule

/* hw/rtl/shdb_weight.sv */
// ----------------------------------------------------------------------------
// shdb_weight
// sine table lookup with linear interpolation and the smoothed heaviside
// weight in q1.16
// ----------------------------------------------------------------------------
module shdb_weight #(
  parameter int unsigned SINE_TABLE_ADDR_BITS = 8,
  parameter int unsigned FRAC_BITS            = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  shdb_pkg::shdb_ctl_t ctl_i,
  input  logic [62:0]         prod_i,
  output logic                valid_o,
  output logic [16:0]         h_o
);
  import shdb_pkg::*;

  localparam int unsigned B      = SINE_TABLE_ADDR_BITS;
  localparam int unsigned TAB_N  = 1 << B;
  localparam int unsigned SHIFT  = 2 * FRAC_BITS - 16;
  localparam logic [B:0]  IDX_LAST = (B+1)'(TAB_N);

  logic [15:0] sine_tab [TAB_N+1];

  shdb_ctl_t          s3_ctl_q;
  logic [16:0]        s3_a_d, s3_a_q;
  logic [15:0]        s3_t0_d, s3_t0_q;
  logic [15:0]        s3_dmag_d, s3_dmag_q;
  logic               s3_dneg_d, s3_dneg_q;
  logic [15:0]        s3_f_d, s3_f_q;
  logic [62:0]        scaled;
  logic [B:0]         idx;
  logic [B:0]         idx_next;
  logic [15:0]        t1;
  logic signed [16:0] diff;

  logic               s4_valid_q;
  logic [16:0]        s4_h_d, s4_h_q;
  logic [32:0]        r_full;
  logic [16:0]        r;
  logic [16:0]        s;
  logic [17:0]        t;
  logic [18:0]        h2;
  logic [18:0]        h_half;

  // constant sine table, one entry per address plus the end point
  for (genvar k = 0; k <= TAB_N; k++) begin : g_tab
    assign sine_tab[k] = sine_entry(k, B);
  end

  // scaled magnitude saturated to one, table address and fraction
  always_comb begin
    scaled   = prod_i >> SHIFT;
    s3_a_d   = (scaled > 63'(H_ONE)) ? H_ONE : scaled[16:0];
    idx      = (B+1)'(s3_a_d >> (16 - B));
    idx_next = (idx == IDX_LAST) ? IDX_LAST : idx + 1'b1;
    s3_f_d   = (idx == IDX_LAST) ? 16'd0 : 16'(s3_a_d[15:0] << B);
    s3_t0_d  = sine_tab[idx];
    t1       = sine_tab[idx_next];
    diff     = $signed({1'b0, t1}) - $signed({1'b0, s3_t0_d});
    s3_dneg_d = diff[16];
    s3_dmag_d = diff[16] ? 16'(17'd0 - $unsigned(diff)) : diff[15:0];
  end

  // interpolation, fold by sign and halving to the weight
  always_comb begin
    r_full = 33'(s3_dmag_q) * 33'(s3_f_q) + 33'd32768;
    r      = 17'(r_full >> 16);
    s      = s3_dneg_q ? 17'({1'b0, s3_t0_q} - r) : 17'({1'b0, s3_t0_q} + r);
    t      = 18'(s3_a_q) + 18'(s);
    if (!s3_ctl_q.neg) begin
      h2 = 19'(H_ONE) + 19'(t);
    end else if (t > 18'(H_ONE)) begin
      h2 = 19'd0;
    end else begin
      h2 = 19'(H_ONE) - 19'(t);
    end
    h_half = (h2 + 19'd1) >> 1;
    if (s3_ctl_q.above) begin
      s4_h_d = H_ONE;
    end else if (s3_ctl_q.below) begin
      s4_h_d = 17'd0;
    end else if (h_half > 19'(H_ONE)) begin
      s4_h_d = H_ONE;
    end else begin
      s4_h_d = h_half[16:0];
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q   <= '0;
      s4_valid_q <= 1'b0;
    end else if (adv_i) begin
      s3_ctl_q   <= ctl_i;
      s4_valid_q <= s3_ctl_q.valid;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_a_q    <= s3_a_d;
      s3_t0_q   <= s3_t0_d;
      s3_dmag_q <= s3_dmag_d;
      s3_dneg_q <= s3_dneg_d;
      s3_f_q    <= s3_f_d;
      s4_h_q    <= s4_h_d;
    end
  end

  assign valid_o = s4_valid_q;
  assign h_o     = s4_h_q;

endmodule

/* hw/rtl/shdb_blend.sv */
// ----------------------------------------------------------------------------
// shdb_blend
// weighted blend of the two densities with rounding and saturation
// ----------------------------------------------------------------------------
module shdb_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [16:0] h_i,
  input  logic [31:0] rho_heavy_i,
  input  logic [31:0] rho_light_i,
  output logic        valid_o,
  output logic [31:0] density_o,
  output logic [16:0] heaviside_o
);
  import shdb_pkg::*;

  logic        s5_valid_q;
  logic [48:0] s5_heavy_d, s5_heavy_q;
  logic [48:0] s5_light_d, s5_light_q;
  logic [16:0] s5_h_q;
  logic        s6_valid_q;
  logic [31:0] s6_density_d, s6_density_q;
  logic [16:0] s6_h_q;
  logic [49:0] sum;
  logic [33:0] rounded;

  // the two weighted products
  assign s5_heavy_d = 49'(rho_heavy_i) * 49'(h_i);
  assign s5_light_d = 49'(rho_light_i) * 49'(H_ONE - h_i);

  // round to q16.16 and saturate
  always_comb begin
    sum          = 50'(s5_heavy_q) + 50'(s5_light_q) + 50'd32768;
    rounded      = 34'(sum >> 16);
    s6_density_d = (rounded > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : rounded[31:0];
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else if (adv_i) begin
      s5_valid_q <= valid_i;
      s6_valid_q <= s5_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s5_heavy_q   <= s5_heavy_d;
      s5_light_q   <= s5_light_d;
      s5_h_q       <= h_i;
      s6_density_q <= s6_density_d;
      s6_h_q       <= s5_h_q;
    end
  end

  assign valid_o     = s6_valid_q;
  assign density_o   = s6_density_q;
  assign heaviside_o = s6_h_q;

endmodule

/* hw/rtl/smoothed_heaviside_density_blend_core.sv */
// ----------------------------------------------------------------------------
// smoothed_heaviside_density_blend_core
// two-phase density from a signed level-set sample through a smoothed
// heaviside weight
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  in       | input     | in_valid_i / in_ready_o   | phi_i
//  out      | output    | out_valid_o / out_ready_i | density_o, heaviside_o
//  cfg      | input     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
//  one word per cycle sustained while the output is taken; six register stages
//  (band test, multiply, table read, interpolation, blend products, rounding)
//  a stalled output holds every stage; in_ready_o is low only while the output
//  register is full and not taken
//  reset clears the stage valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module smoothed_heaviside_density_blend_core #(
  parameter int unsigned SINE_TABLE_ADDR_BITS = 8,
  parameter int unsigned FRAC_BITS            = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [31:0]              phi_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [31:0]                     density_o,
  output logic [16:0]                     heaviside_o,
  input  logic                            cfg_we_i,
  input  logic [shdb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import shdb_pkg::*;

  logic [30:0] half_width_q;
  logic [30:0] inv_half_width_q;
  logic [31:0] rho_heavy_q;
  logic [31:0] rho_light_q;
  logic        adv;
  shdb_ctl_t   scale_ctl;
  logic [62:0] scale_prod;
  logic        weight_valid;
  logic [16:0] weight_h;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q     <= HALF_WIDTH_RST;
      inv_half_width_q <= INV_HALF_WIDTH_RST;
      rho_heavy_q      <= RHO_HEAVY_RST;
      rho_light_q      <= RHO_LIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_HALF_WIDTH:     half_width_q     <= cfg_data_i[30:0];
        REG_INV_HALF_WIDTH: inv_half_width_q <= cfg_data_i[30:0];
        REG_RHO_HEAVY:      rho_heavy_q      <= cfg_data_i;
        REG_RHO_LIGHT:      rho_light_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output word is held
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  shdb_scale u_scale (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .valid_i          (in_valid_i),
    .phi_i            (phi_i),
    .half_width_i     (half_width_q),
    .inv_half_width_i (inv_half_width_q),
    .ctl_o            (scale_ctl),
    .prod_o           (scale_prod)
  );

  shdb_weight #(
    .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
    .FRAC_BITS            (FRAC_BITS)
  ) u_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .ctl_i   (scale_ctl),
    .prod_i  (scale_prod),
    .valid_o (weight_valid),
    .h_o     (weight_h)
  );

  shdb_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (weight_valid),
    .h_i         (weight_h),
    .rho_heavy_i (rho_heavy_q),
    .rho_light_i (rho_light_q),
    .valid_o     (out_valid_o),
    .density_o   (density_o),
    .heaviside_o (heaviside_o)
  );

endmodule

/* hw/rtl/shdb_checker.sv */
// ----------------------------------------------------------------------------
// shdb_checker
// port-level checks for the density blend core, bound to the top level
// ----------------------------------------------------------------------------
module shdb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] density_o,
  input logic [16:0] heaviside_o
);
  import shdb_pkg::*;

  // weight never exceeds one
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heaviside_o <= H_ONE))
    else $error("heaviside weight above one");

  // input is taken whenever the output register is free or being drained
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not track output stage");

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(density_o) && $stable(heaviside_o)))
    else $error("output word changed while stalled");

  // a stalled output word keeps the input from taking a word
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && in_valid_i) |-> !in_ready_o)
    else $error("word accepted while output stalled");

endmodule

bind smoothed_heaviside_density_blend_core shdb_checker u_shdb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .density_o   (density_o),
  .heaviside_o (heaviside_o)
);
